// ----- rtl/core/mpi_pkg.sv -----
package mpi_pkg;

   localparam int FRAME_BITS    = 12;
   localparam int POS_FRAC_BITS = 16;
   localparam int EXTRA_FRAC    = 16;
   localparam int POS_W         = 32;
   localparam int VEL_W         = 48;
   localparam int HALF_W        = FRAME_BITS - 1;
   // divisor is at most f*f
   localparam int DVS_W         = 2 * FRAME_BITS;
   // |delta| * 2^EXTRA_FRAC * 4 fits here
   localparam int DVD_W         = POS_W + EXTRA_FRAC + 2;
   localparam int QUO_W         = DVD_W + 2;
   localparam int CNT_W         = $clog2(DVD_W);
   localparam int DIST_W        = POS_FRAC_BITS + 1;
   localparam int SQ_W          = 2 * DIST_W + 2;

   typedef enum logic [2:0] {
      CMD_TICK,
      CMD_LINEAR,
      CMD_DECEL,
      CMD_SMOOTH,
      CMD_SET_DEST,
      CMD_STOP,
      CMD_SET_POS,
      CMD_NUDGE
   } mpi_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_QUOT,
      ST_MUL,
      ST_APPLY,
      ST_DIST,
      ST_SQR,
      ST_OUT
   } mpi_state_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic div_step;
      logic quot;
      logic mul;
      logic apply;
      logic measure;
      logic sqr;
      logic out_load;
   } mpi_ctl_type;

   typedef struct packed {
      logic is_move;
      logic is_decel;
   } mpi_sts_type;

   function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (VEL_W - 1)) - 64'sd1;
      lo = -(64'sd1 <<< (VEL_W - 1));
      if (v > hi) return hi[VEL_W-1:0];
      else if (v < lo) return lo[VEL_W-1:0];
      else return v[VEL_W-1:0];
   endfunction

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (POS_W - 1)) - 64'sd1;
      lo = -(64'sd1 <<< (POS_W - 1));
      if (v > hi) return hi[POS_W-1:0];
      else if (v < lo) return lo[POS_W-1:0];
      else return v[POS_W-1:0];
   endfunction

endpackage

// ----- rtl/core/mpi_ctrl.sv -----
module mpi_ctrl import mpi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  mpi_sts_type sts,
   output mpi_ctl_type ctl
);

   mpi_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ctl          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            ctl.prep = 1'b1;
            cnt_in   = CNT_W'(DVD_W - 1);
            state_in = sts.is_move ? ST_DIV : ST_APPLY;
         end
         ST_DIV: begin
            ctl.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = ST_QUOT;
         end
         ST_QUOT: begin
            ctl.quot = 1'b1;
            state_in = sts.is_decel ? ST_MUL : ST_APPLY;
         end
         ST_MUL: begin
            ctl.mul  = 1'b1;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            ctl.apply = 1'b1;
            state_in  = ST_DIST;
         end
         ST_DIST: begin
            ctl.measure = 1'b1;
            state_in    = ST_SQR;
         end
         ST_SQR: begin
            ctl.sqr  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               ctl.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside output state");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_PREP))
      else $error("accepted transfer did not start work");

endmodule

// ----- rtl/core/mpi_datapath.sv -----
module mpi_datapath import mpi_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  mpi_ctl_type             ctl,
   output mpi_sts_type             sts,
   input  logic [2:0]              req_command,
   input  logic signed [POS_W-1:0] req_dest_x,
   input  logic signed [POS_W-1:0] req_dest_y,
   input  logic signed [POS_W-1:0] req_dest_z,
   input  logic [11:0]             req_frames,
   output logic signed [POS_W-1:0] rsp_pos_x,
   output logic signed [POS_W-1:0] rsp_pos_y,
   output logic signed [POS_W-1:0] rsp_pos_z,
   output logic                    rsp_moving,
   output logic                    rsp_timed_active
);

   mpi_cmd_type             cmd_ff;
   logic signed [POS_W-1:0] arg_ff [3];
   logic [FRAME_BITS-1:0]   f_ff;

   logic signed [POS_W-1:0] pos_ff [3];
   logic signed [POS_W-1:0] dst_ff [3];
   logic signed [VEL_W-1:0] vel_ff [3];
   logic signed [VEL_W-1:0] acc_ff [3];
   logic [FRAME_BITS-1:0]   fl_ff;
   logic [HALF_W-1:0]       half_ff;
   logic                    smooth_ff;

   logic [DVS_W-1:0]        den_ff;
   logic [DVS_W-1:0]        rem_ff [3];
   logic [DVD_W-1:0]        quo_ff [3];
   logic                    neg_ff [3];

   logic [DIST_W-1:0]       dlo_ff [3];
   logic                    big_ff;
   logic                    far_ff;

   logic signed [POS_W-1:0] rsp_pos_ff [3];
   logic                    rsp_moving_ff;
   logic                    rsp_timed_ff;

   // combinational helpers
   logic [FRAME_BITS-1:0]   f_eff;
   logic [DVS_W:0]          den_in;
   logic signed [POS_W:0]   diff  [3];
   logic [POS_W-1:0]        mag   [3];
   logic [DVD_W-1:0]        dvd   [3];
   logic [DVS_W:0]          rsh   [3];
   logic                    qbit  [3];
   logic signed [QUO_W-1:0] qs    [3];
   logic signed [63:0]      prod  [3];
   logic signed [63:0]      step  [3];
   logic signed [POS_W-1:0] npos  [3];
   logic signed [POS_W:0]   creep [3];
   logic signed [POS_W:0]   dd    [3];
   logic [POS_W:0]          ad    [3];
   logic [FRAME_BITS-1:0]   fl_dec;
   logic [SQ_W-1:0]         sq_sum;
   logic                    big_in;

   assign sts.is_move  = (cmd_ff == CMD_LINEAR) || (cmd_ff == CMD_DECEL)
                         || (cmd_ff == CMD_SMOOTH);
   assign sts.is_decel = (cmd_ff == CMD_DECEL);

   always_comb begin
      f_eff  = (f_ff == '0) ? FRAME_BITS'(1) : f_ff;
      fl_dec = fl_ff - 1'b1;
      case (cmd_ff)
         CMD_DECEL:  den_in = ((DVS_W+1)'(f_eff) * ((DVS_W+1)'(f_eff) + 1'b1)) >> 1;
         CMD_SMOOTH: den_in = (DVS_W+1)'(f_eff) * (DVS_W+1)'(f_eff);
         default:    den_in = (DVS_W+1)'(f_eff);
      endcase
      big_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         diff[i] = (POS_W+1)'(arg_ff[i]) - (POS_W+1)'(pos_ff[i]);
         mag[i]  = diff[i][POS_W] ? POS_W'(-diff[i]) : POS_W'(diff[i]);
         dvd[i]  = DVD_W'(mag[i]) << (EXTRA_FRAC + ((cmd_ff == CMD_SMOOTH) ? 2 : 0));
         rsh[i]  = {rem_ff[i], quo_ff[i][DVD_W-1]};
         qbit[i] = (rsh[i] >= (DVS_W+1)'(den_ff));
         qs[i]   = neg_ff[i] ? -$signed(QUO_W'(quo_ff[i])) : $signed(QUO_W'(quo_ff[i]));
         prod[i] = 64'(acc_ff[i]) * 64'($signed({1'b0, f_eff}));
         step[i] = (64'(vel_ff[i]) + (64'sd1 <<< (EXTRA_FRAC - 1))) >>> EXTRA_FRAC;
         npos[i] = sat_pos(64'(pos_ff[i]) + step[i]);
         creep[i] = ((POS_W+1)'(dst_ff[i]) - (POS_W+1)'(pos_ff[i])) >>> 3;
         dd[i]   = (POS_W+1)'(pos_ff[i]) - (POS_W+1)'(dst_ff[i]);
         ad[i]   = dd[i][POS_W] ? (POS_W+1)'(-dd[i]) : (POS_W+1)'(dd[i]);
         if (ad[i] > (POS_W+1)'(1 << POS_FRAC_BITS)) big_in = 1'b1;
      end
      sq_sum = SQ_W'(dlo_ff[0] * dlo_ff[0]) + SQ_W'(dlo_ff[1] * dlo_ff[1])
               + SQ_W'(dlo_ff[2] * dlo_ff[2]);
   end

   // motion state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
            dst_ff[i] <= '0;
            vel_ff[i] <= '0;
            acc_ff[i] <= '0;
         end
         fl_ff     <= '0;
         half_ff   <= '0;
         smooth_ff <= 1'b0;
      end else if (ctl.quot) begin
         for (int i = 0; i < 3; i++) begin
            case (cmd_ff)
               CMD_LINEAR: begin
                  vel_ff[i] <= sat_vel(64'(qs[i]));
                  acc_ff[i] <= '0;
               end
               CMD_DECEL: acc_ff[i] <= sat_vel(-64'(qs[i]));
               default: begin
                  vel_ff[i] <= '0;
                  acc_ff[i] <= sat_vel(64'(qs[i]));
               end
            endcase
         end
      end else if (ctl.mul) begin
         for (int i = 0; i < 3; i++) vel_ff[i] <= sat_vel(-prod[i]);
      end else if (ctl.apply) begin
         case (cmd_ff)
            CMD_TICK: begin
               if (fl_ff != '0) begin
                  for (int i = 0; i < 3; i++) begin
                     pos_ff[i] <= (fl_dec == '0) ? dst_ff[i] : npos[i];
                     vel_ff[i] <= sat_vel(64'(vel_ff[i]) + 64'(acc_ff[i]));
                     // reverse acceleration at the half mark
                     if (smooth_ff && fl_dec == FRAME_BITS'(half_ff))
                        acc_ff[i] <= sat_vel(-64'(acc_ff[i]));
                  end
                  fl_ff <= fl_dec;
                  if (smooth_ff && fl_dec == FRAME_BITS'(half_ff)) smooth_ff <= 1'b0;
               end else begin
                  for (int i = 0; i < 3; i++)
                     pos_ff[i] <= POS_W'((POS_W+1)'(pos_ff[i]) + creep[i]);
               end
            end
            CMD_LINEAR, CMD_DECEL, CMD_SMOOTH: begin
               for (int i = 0; i < 3; i++) dst_ff[i] <= arg_ff[i];
               smooth_ff <= (cmd_ff == CMD_SMOOTH);
               if (cmd_ff == CMD_SMOOTH) half_ff <= HALF_W'(f_eff >> 1);
               fl_ff <= f_eff;
            end
            CMD_SET_DEST: begin
               for (int i = 0; i < 3; i++) dst_ff[i] <= arg_ff[i];
            end
            CMD_STOP: begin
               for (int i = 0; i < 3; i++) begin
                  dst_ff[i] <= pos_ff[i];
                  vel_ff[i] <= '0;
                  acc_ff[i] <= '0;
               end
               fl_ff <= '0;
            end
            CMD_SET_POS: begin
               for (int i = 0; i < 3; i++) begin
                  pos_ff[i] <= arg_ff[i];
                  dst_ff[i] <= arg_ff[i];
               end
            end
            default: begin
               for (int i = 0; i < 3; i++) begin
                  pos_ff[i] <= sat_pos(64'(pos_ff[i]) + 64'(arg_ff[i]));
                  dst_ff[i] <= sat_pos(64'(pos_ff[i]) + 64'(arg_ff[i]));
               end
            end
         endcase
      end
   end

   // input latch, divider lanes, distance and result registers
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff    <= mpi_cmd_type'(req_command);
         arg_ff[0] <= req_dest_x;
         arg_ff[1] <= req_dest_y;
         arg_ff[2] <= req_dest_z;
         f_ff      <= req_frames[FRAME_BITS-1:0];
      end
      if (ctl.prep) begin
         den_ff <= DVS_W'(den_in);
         for (int i = 0; i < 3; i++) begin
            rem_ff[i] <= '0;
            quo_ff[i] <= dvd[i];
            neg_ff[i] <= diff[i][POS_W];
         end
      end else if (ctl.div_step) begin
         for (int i = 0; i < 3; i++) begin
            rem_ff[i] <= qbit[i] ? DVS_W'(rsh[i] - (DVS_W+1)'(den_ff)) : DVS_W'(rsh[i]);
            quo_ff[i] <= {quo_ff[i][DVD_W-2:0], qbit[i]};
         end
      end
      if (ctl.measure) begin
         big_ff <= big_in;
         for (int i = 0; i < 3; i++) dlo_ff[i] <= ad[i][DIST_W-1:0];
      end
      if (ctl.sqr)
         far_ff <= big_ff || (sq_sum > SQ_W'(64'd1 << (2 * POS_FRAC_BITS)));
      if (ctl.out_load) begin
         for (int i = 0; i < 3; i++) rsp_pos_ff[i] <= pos_ff[i];
         rsp_moving_ff <= far_ff;
         rsp_timed_ff  <= (fl_ff != '0);
      end
   end

   assign rsp_pos_x        = rsp_pos_ff[0];
   assign rsp_pos_y        = rsp_pos_ff[1];
   assign rsp_pos_z        = rsp_pos_ff[2];
   assign rsp_moving       = rsp_moving_ff;
   assign rsp_timed_active = rsp_timed_ff;

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      ctl.div_step |=> (rem_ff[0] < den_ff) && (rem_ff[1] < den_ff)
                       && (rem_ff[2] < den_ff))
      else $error("divider remainder out of range");

   a_snap_on_last: assert property (@(posedge clock) disable iff (reset)
      (ctl.apply && cmd_ff == CMD_TICK && fl_ff == FRAME_BITS'(1))
      |=> (pos_ff[0] == dst_ff[0]) && (pos_ff[1] == dst_ff[1])
          && (pos_ff[2] == dst_ff[2]))
      else $error("position not at destination after last frame");

endmodule

// ----- rtl/core/motion_profile_interpolator.sv -----
// Three-axis motion tweener, Q16.16 positions.
// Input channel req_*: one command per transfer (tick, timed moves, set
// destination, stop, set position, nudge) with x/y/z operand and frame count.
// Result channel rsp_*: exactly one transfer per command, carrying the
// position after the command, the moving flag and the timed-move flag.
// Work is one command at a time; req_stall stays high until the result
// is placed in the output register.
// Every command passes the prep, apply, distance, square and output states;
// moves add the divider and a quotient state, decelerating moves also a multiply.
// Moves use the restoring divider, one quotient bit per cycle over a 50-bit
// dividend, with the three axes in parallel lanes.
// The next command is taken only once the previous one has left its output
// state, and may be taken while the previous result still waits in the output
// register.
// If rsp_stall holds, the next result waits in its final state until the
// output register frees up.
// Reset (synchronous) clears position, destination, velocity, acceleration
// and frame counters to zero and drops any pending result.
module motion_profile_interpolator import mpi_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [2:0]              req_command,
   input  logic signed [POS_W-1:0] req_dest_x,
   input  logic signed [POS_W-1:0] req_dest_y,
   input  logic signed [POS_W-1:0] req_dest_z,
   input  logic [11:0]             req_frames,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [POS_W-1:0] rsp_pos_x,
   output logic signed [POS_W-1:0] rsp_pos_y,
   output logic signed [POS_W-1:0] rsp_pos_z,
   output logic                    rsp_moving,
   output logic                    rsp_timed_active
);

   mpi_ctl_type ctl;
   mpi_sts_type sts;

   mpi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   mpi_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .sts              (sts),
      .req_command      (req_command),
      .req_dest_x       (req_dest_x),
      .req_dest_y       (req_dest_y),
      .req_dest_z       (req_dest_z),
      .req_frames       (req_frames),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_pos_z        (rsp_pos_z),
      .rsp_moving       (rsp_moving),
      .rsp_timed_active (rsp_timed_active)
   );

endmodule

// ----- sim/tb_motion_profile_interpolator.sv -----
module tb_motion_profile_interpolator;
   import mpi_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint MAX32 = 64'sd2147483647;
   localparam longint MIN32 = -64'sd2147483648;
   localparam longint MAX48 = (64'sd1 <<< 47) - 64'sd1;
   localparam longint MIN48 = -(64'sd1 <<< 47);
   localparam longint UNIT  = 64'sd1 <<< POS_FRAC_BITS;
   localparam int     N_RANDOM = 1630;

   typedef struct {
      logic [31:0] x, y, z;
      bit          moving;
      bit          timed;
   } position_report_type;

   typedef struct {
      mpi_cmd_type cmd;
      logic [31:0] x, y, z;
      logic [11:0] frames;
      bit          typed;
      logic [31:0] ex, ey, ez;
      bit          em, et;
   } stim_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [2:0]              req_command = CMD_TICK;
   logic signed [POS_W-1:0] req_dest_x = '0;
   logic signed [POS_W-1:0] req_dest_y = '0;
   logic signed [POS_W-1:0] req_dest_z = '0;
   logic [11:0]             req_frames = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [POS_W-1:0] rsp_pos_x;
   logic signed [POS_W-1:0] rsp_pos_y;
   logic signed [POS_W-1:0] rsp_pos_z;
   logic                    rsp_moving;
   logic                    rsp_timed_active;

   // tweener state mirror
   longint pos[3], dst[3], vel[3], acc[3];
   int     frames_left, half_mark;
   bit     smooth_pending;

   position_report_type pending_positions[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   motion_profile_interpolator DUT (.*);

   always #5 clock = ~clock;

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic position_report_type tween_step(mpi_cmd_type cmd, logic [31:0] ax,
                                                      logic [31:0] ay, logic [31:0] az,
                                                      logic [11:0] fr);
      longint arg[3];
      longint f, delta, d, dsum;
      bit far;
      position_report_type r;
      arg[0] = longint'($signed(ax));
      arg[1] = longint'($signed(ay));
      arg[2] = longint'($signed(az));
      f = (fr == 0) ? 1 : longint'(fr);
      far = 0;
      dsum = 0;
      case (cmd)
         CMD_TICK: begin
            if (frames_left > 0) begin
               for (int i = 0; i < 3; i++) begin
                  pos[i] = clamp(pos[i] + ((vel[i] + 64'sd32768) >>> EXTRA_FRAC), MIN32, MAX32);
                  vel[i] = clamp(vel[i] + acc[i], MIN48, MAX48);
               end
               frames_left--;
               if (frames_left == 0)
                  for (int i = 0; i < 3; i++) pos[i] = dst[i];
               // reverse the push at the midpoint of a smooth move
               if (smooth_pending && frames_left == half_mark) begin
                  for (int i = 0; i < 3; i++) acc[i] = clamp(-acc[i], MIN48, MAX48);
                  smooth_pending = 0;
               end
            end else begin
               for (int i = 0; i < 3; i++) pos[i] += (dst[i] - pos[i]) >>> 3;
            end
         end
         CMD_LINEAR, CMD_DECEL, CMD_SMOOTH: begin
            for (int i = 0; i < 3; i++) begin
               delta = (arg[i] - pos[i]) * (64'sd1 <<< EXTRA_FRAC);
               if (cmd == CMD_LINEAR) begin
                  acc[i] = 0;
                  vel[i] = clamp(delta / f, MIN48, MAX48);
               end else if (cmd == CMD_DECEL) begin
                  acc[i] = clamp(-(delta / ((f * (f + 1)) / 2)), MIN48, MAX48);
                  vel[i] = clamp(-(acc[i] * f), MIN48, MAX48);
               end else begin
                  vel[i] = 0;
                  acc[i] = clamp((delta * 4) / (f * f), MIN48, MAX48);
               end
               dst[i] = arg[i];
            end
            smooth_pending = (cmd == CMD_SMOOTH);
            if (cmd == CMD_SMOOTH) half_mark = int'(f / 2);
            frames_left = int'(f);
         end
         CMD_SET_DEST: for (int i = 0; i < 3; i++) dst[i] = arg[i];
         CMD_STOP: begin
            for (int i = 0; i < 3; i++) begin
               dst[i] = pos[i];
               vel[i] = 0;
               acc[i] = 0;
            end
            frames_left = 0;
         end
         CMD_SET_POS: for (int i = 0; i < 3; i++) begin
            pos[i] = arg[i];
            dst[i] = arg[i];
         end
         default: for (int i = 0; i < 3; i++) begin
            pos[i] = clamp(pos[i] + arg[i], MIN32, MAX32);
            dst[i] = pos[i];
         end
      endcase
      for (int i = 0; i < 3; i++) begin
         d = pos[i] - dst[i];
         if (d < 0) d = -d;
         if (d > UNIT) far = 1;
         dsum += d * d;
      end
      if (!far) far = dsum > UNIT * UNIT;
      r.x = pos[0][31:0];
      r.y = pos[1][31:0];
      r.z = pos[2][31:0];
      r.moving = far;
      r.timed = frames_left != 0;
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
      errors++;
   endtask

   // drive one command and hold it until the transfer happens
   task automatic send_command(mpi_cmd_type cmd, logic [31:0] x, logic [31:0] y,
                               logic [31:0] z, logic [11:0] fr, bit typed = 0,
                               position_report_type typed_result = '{default: 0});
      position_report_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_dest_x  <= x;
      req_dest_y  <= y;
      req_dest_z  <= z;
      req_frames  <= fr;
      do @(negedge clock); while (req_stall);
      r = tween_step(cmd, x, y, z, fr);
      pending_positions.push_back(typed ? typed_result : r);
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(4))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2097152)) - 1048576);
         2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
         default: return 32'($signed($urandom_range(400000)) - 200000);
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= $urandom_range(99) < recv_stall_pct;
   end

   always @(negedge clock) begin
      position_report_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_positions.size() == 0) begin
            $display("unexpected result transfer at %0t", $realtime);
            errors++;
         end else begin
            w = pending_positions.pop_front();
            if (rsp_pos_x !== w.x) report_mismatch("pos_x", rsp_pos_x, w.x);
            if (rsp_pos_y !== w.y) report_mismatch("pos_y", rsp_pos_y, w.y);
            if (rsp_pos_z !== w.z) report_mismatch("pos_z", rsp_pos_z, w.z);
            if (rsp_moving !== w.moving) report_mismatch("moving", rsp_moving, w.moving);
            if (rsp_timed_active !== w.timed)
               report_mismatch("timed_active", rsp_timed_active, w.timed);
         end
      end
   end

   initial begin
      #10ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      stim_row_type rows[] = '{
         '{CMD_TICK,     32'h0, 32'h0, 32'h0, 12'h0, 1, 32'h0, 32'h0, 32'h0, 0, 0},
         '{CMD_SET_POS,  32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 12'hfff, 1,
           32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0},
         '{CMD_NUDGE,    32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 12'h0, 1,
           32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0},
         '{CMD_SET_POS,  32'h80000000, 32'h80000000, 32'h80000000, 12'h0, 1,
           32'h80000000, 32'h80000000, 32'h80000000, 0, 0},
         '{CMD_NUDGE,    32'h80000000, 32'h80000000, 32'h80000000, 12'h0, 1,
           32'h80000000, 32'h80000000, 32'h80000000, 0, 0},
         '{CMD_LINEAR,   32'h7fffffff, 32'h7fffffff, 32'h0, 12'h0, 0, 0, 0, 0, 0, 0},
         '{CMD_TICK,     32'h0, 32'h0, 32'h0, 12'h0, 0, 0, 0, 0, 0, 0},
         '{CMD_DECEL,    32'h80000000, 32'h7fffffff, 32'h00012345, 12'h3, 0, 0, 0, 0, 0, 0},
         '{CMD_TICK,     32'h0, 32'h0, 32'h0, 12'h0, 0, 0, 0, 0, 0, 0},
         '{CMD_TICK,     32'h0, 32'h0, 32'h0, 12'h0, 0, 0, 0, 0, 0, 0},
         '{CMD_TICK,     32'h0, 32'h0, 32'h0, 12'h0, 0, 0, 0, 0, 0, 0},
         '{CMD_SMOOTH,   32'h00100000, 32'hfff00000, 32'h7fffffff, 12'h4, 0, 0, 0, 0, 0, 0},
         '{CMD_TICK,     32'h0, 32'h0, 32'h0, 12'h0, 0, 0, 0, 0, 0, 0},
         '{CMD_TICK,     32'h0, 32'h0, 32'h0, 12'h0, 0, 0, 0, 0, 0, 0},
         '{CMD_TICK,     32'h0, 32'h0, 32'h0, 12'h0, 0, 0, 0, 0, 0, 0},
         '{CMD_TICK,     32'h0, 32'h0, 32'h0, 12'h0, 0, 0, 0, 0, 0, 0},
         '{CMD_SMOOTH,   32'h80000000, 32'h0, 32'h1, 12'h1, 0, 0, 0, 0, 0, 0},
         '{CMD_TICK,     32'h0, 32'h0, 32'h0, 12'h0, 0, 0, 0, 0, 0, 0},
         '{CMD_SET_DEST, 32'h00008000, 32'h00008000, 32'h00008000, 12'h0, 0, 0, 0, 0, 0, 0},
         '{CMD_TICK,     32'h0, 32'h0, 32'h0, 12'h0, 0, 0, 0, 0, 0, 0},
         '{CMD_TICK,     32'h0, 32'h0, 32'h0, 12'h0, 0, 0, 0, 0, 0, 0},
         '{CMD_LINEAR,   32'h12345678, 32'h80000001, 32'h7ffffffe, 12'hfff, 0, 0, 0, 0, 0, 0},
         '{CMD_TICK,     32'h0, 32'h0, 32'h0, 12'h0, 0, 0, 0, 0, 0, 0},
         '{CMD_STOP,     32'hffffffff, 32'hffffffff, 32'hffffffff, 12'hfff, 0, 0, 0, 0, 0, 0},
         '{CMD_TICK,     32'h0, 32'h0, 32'h0, 12'h0, 0, 0, 0, 0, 0, 0}
      };
      position_report_type t;
      mpi_cmd_type cmd;
      int sent;
      int fr;
      int wait_cycles;

      for (int i = 0; i < 3; i++) begin
         pos[i] = 0; dst[i] = 0; vel[i] = 0; acc[i] = 0;
      end
      frames_left = 0;
      half_mark = 0;
      smooth_pending = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         t = '{rows[i].ex, rows[i].ey, rows[i].ez, rows[i].em, rows[i].et};
         send_command(rows[i].cmd, rows[i].x, rows[i].y, rows[i].z, rows[i].frames,
                      rows[i].typed, t);
      end

      sent = 0;
      while (sent < N_RANDOM) begin
         case (sent * 4 / N_RANDOM)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
         endcase
         if ($urandom_range(99) < 70) begin
            // well-formed move: optional placement, move, ticks, optional stop
            if ($urandom_range(2) == 0) begin
               send_command(CMD_SET_POS, rand_coord(), rand_coord(), rand_coord(),
                            12'($urandom));
               sent++;
            end
            cmd = mpi_cmd_type'($urandom_range(CMD_LINEAR, CMD_SMOOTH));
            fr = ($urandom_range(15) == 0) ? $urandom_range(4095) : $urandom_range(24);
            send_command(cmd, rand_coord(), rand_coord(), rand_coord(), 12'(fr));
            sent++;
            if (fr > 30) fr = $urandom_range(6);
            for (int k = 0; k < fr + $urandom_range(3); k++) begin
               send_command(CMD_TICK, $urandom, $urandom, $urandom, 12'($urandom));
               sent++;
            end
            if ($urandom_range(4) == 0) begin
               send_command(CMD_STOP, $urandom, $urandom, $urandom, 12'($urandom));
               sent++;
            end
         end else begin
            send_command(mpi_cmd_type'($urandom_range(7)), rand_coord(), rand_coord(),
                         rand_coord(), 12'($urandom));
            sent++;
         end
      end
      req_valid <= 1'b0;

      wait_cycles = 0;
      while (pending_positions.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (80) @(posedge clock);
      if (errors == 0 && pending_positions.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
